@@ rtl/tcsac_pkg.sv @@
// Package for the two-class server admission counter.
// Field widths, register indexes and fixed constants; no dependencies.
package tcsac_pkg;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int BUSY_W   = 9;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SERVERS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_A_CAPACITY = 1'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

@@ rtl/tcsac_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcsac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/two_class_server_admission_counter.sv @@
// Two-class server admission counter, top level.
// Uses tcsac_pkg and tcsac_ram (end-time store for both classes).
//
//  channel | ports                      | payload (lsb first)
//  input   | s_tvalid s_tready s_tdata  | restart, arrival_time, departure_time
//          | s_tuser                    | traffic_class
//  result  | m_tvalid m_tready m_tdata  | admitted, admitted_total, class_busy
//  config  | cfg_we cfg_index cfg_data  | total_servers (0), class_a_capacity (1)
//
// For each item, the shared compare unit walks the busy list of its class once, one entry
// a cycle, packing the survivors (entries ending at or after the item's arrival); then the
// item is decided and the new entry is appended when the item is admitted.
// The end-time store is kept dense per class and sized by the busy counts, so reset
// needs no clearing pass; reset clears counts, capacities and the handshake state.
// s_tready is high only while the sequencer is idle; a result waiting in the output
// register stalls the decision of the next item, not its scan.
module two_class_server_admission_counter #(
    parameter int MAX_SERVERS = 256
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // config
    input  logic                                   cfg_we,
    input  logic [tcsac_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tcsac_pkg::CFG_W-1:0]            cfg_data,
    // input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [0] restart, [32:1] arrival_time, [64:33] departure_time, rest zero
    input  logic [tcsac_pkg::S_TDATA_W-1:0]        s_tdata,
    // [0] traffic_class
    input  logic                                   s_tuser,
    // result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [0] admitted, [32:1] admitted_total, [41:33] class_busy, rest zero
    output logic [tcsac_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
    localparam int CAP_W  = (CNT_W > tcsac_pkg::CFG_W) ? CNT_W : tcsac_pkg::CFG_W;
    localparam int RAM_DEPTH = 2 * (1 << IDX_W);
    localparam int ADDR_W = IDX_W + 1;
    localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(MAX_SERVERS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_ALLOC = 2'd2;

    localparam int TW = tcsac_pkg::TIME_W;

    logic [1:0]                      state_reg, state_next;
    logic [tcsac_pkg::CFG_W-1:0]     total_reg, total_next;
    logic [tcsac_pkg::CFG_W-1:0]     cap_a_cfg_reg, cap_a_cfg_next;
    logic [CNT_W-1:0]                busy_a_reg, busy_a_next;
    logic [CNT_W-1:0]                busy_b_reg, busy_b_next;
    logic [tcsac_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                            cls_reg, cls_next;
    logic [TW-1:0]                   arr_reg, arr_next;
    logic [TW-1:0]                   dep_reg, dep_next;
    logic [CNT_W-1:0]                cap_reg, cap_next;
    logic [CNT_W-1:0]                rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]                wr_idx_reg, wr_idx_next;
    logic                            pend_reg, pend_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            out_adm_reg, out_adm_next;
    logic [tcsac_pkg::COUNT_W-1:0]   out_total_reg, out_total_next;
    logic [tcsac_pkg::BUSY_W-1:0]    out_busy_reg, out_busy_next;

    logic                            s_accept;
    logic [CNT_W-1:0]                scan_limit;
    logic [CAP_W-1:0]                cap_a_raw, cap_b_raw, cap_sel;
    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr, ram_raddr;
    logic [TW-1:0]                   ram_wdata, ram_rdata;
    logic                            keep;
    logic                            out_free;
    logic                            admit;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(tcsac_pkg::M_TDATA_W - 1 - tcsac_pkg::COUNT_W
                        - tcsac_pkg::BUSY_W){1'b0}},
                       out_busy_reg, out_total_reg, out_adm_reg};

    // capacity of the incoming item's class, clamped to the pool size
    always_comb begin
        cap_a_raw = CAP_W'(cap_a_cfg_reg);
        cap_b_raw = (total_reg > cap_a_cfg_reg) ? CAP_W'(total_reg - cap_a_cfg_reg)
                                                : '0;
        cap_sel   = s_tuser ? cap_b_raw : cap_a_raw;
        if (cap_sel > MAX_CAP) begin
            cap_sel = MAX_CAP;
        end
    end

    assign scan_limit = cls_reg ? busy_b_reg : busy_a_reg;
    assign keep       = pend_reg && (ram_rdata >= arr_reg);
    assign out_free   = !m_valid_reg || m_tready;
    assign admit      = wr_idx_reg < cap_reg;

    tcsac_ram #(
        .WIDTH (TW),
        .DEPTH (RAM_DEPTH)
    ) u_end_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = {cls_reg, rd_idx_reg[IDX_W-1:0]};
    assign ram_waddr = {cls_reg, wr_idx_reg[IDX_W-1:0]};

    always_comb begin
        state_next     = state_reg;
        total_next     = total_reg;
        cap_a_cfg_next = cap_a_cfg_reg;
        busy_a_next    = busy_a_reg;
        busy_b_next    = busy_b_reg;
        count_next     = count_reg;
        cls_next       = cls_reg;
        arr_next       = arr_reg;
        dep_next       = dep_reg;
        cap_next       = cap_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        pend_next      = 1'b0;
        m_valid_next   = m_valid_reg && !m_tready;
        out_adm_next   = out_adm_reg;
        out_total_next = out_total_reg;
        out_busy_next  = out_busy_reg;
        ram_we         = 1'b0;
        ram_wdata      = arr_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                tcsac_pkg::CFG_TOTAL_SERVERS:    total_next     = cfg_data;
                tcsac_pkg::CFG_CLASS_A_CAPACITY: cap_a_cfg_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cls_next    = s_tuser;
                    arr_next    = s_tdata[TW:1];
                    dep_next    = s_tdata[2*TW:TW+1];
                    cap_next    = CNT_W'(cap_sel);
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    if (s_tdata[0]) begin
                        busy_a_next = '0;
                        busy_b_next = '0;
                        count_next  = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read one entry a cycle; the one read last cycle is checked now
                if (rd_idx_reg != scan_limit) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                if (keep) begin
                    ram_we      = 1'b1;
                    ram_wdata   = ram_rdata;
                    wr_idx_next = wr_idx_reg + 1'b1;
                end
                if (rd_idx_reg == scan_limit && !pend_reg) begin
                    state_next = ST_ALLOC;
                end
            end
            ST_ALLOC: begin
                if (out_free) begin
                    ram_we    = admit;
                    ram_wdata = dep_reg;
                    if (admit) begin
                        if (cls_reg) begin
                            busy_b_next = wr_idx_reg + 1'b1;
                        end else begin
                            busy_a_next = wr_idx_reg + 1'b1;
                        end
                        if (count_reg != tcsac_pkg::COUNT_MAX) begin
                            count_next = count_reg + 1'b1;
                        end
                    end else begin
                        if (cls_reg) begin
                            busy_b_next = wr_idx_reg;
                        end else begin
                            busy_a_next = wr_idx_reg;
                        end
                    end
                    m_valid_next   = 1'b1;
                    out_adm_next   = admit;
                    out_total_next = (admit && count_reg != tcsac_pkg::COUNT_MAX)
                                     ? count_reg + 1'b1 : count_reg;
                    out_busy_next  = admit ? tcsac_pkg::BUSY_W'(wr_idx_reg + 1'b1)
                                           : tcsac_pkg::BUSY_W'(wr_idx_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            cap_a_cfg_reg <= '0;
            busy_a_reg    <= '0;
            busy_b_reg    <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cap_a_cfg_reg <= cap_a_cfg_next;
            busy_a_reg    <= busy_a_next;
            busy_b_reg    <= busy_b_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls_reg       <= cls_next;
        arr_reg       <= arr_next;
        dep_reg       <= dep_next;
        cap_reg       <= cap_next;
        rd_idx_reg    <= rd_idx_next;
        wr_idx_reg    <= wr_idx_next;
        out_adm_reg   <= out_adm_next;
        out_total_reg <= out_total_next;
        out_busy_reg  <= out_busy_next;
    end

`ifndef SYNTHESIS
    a_busy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_a_reg <= CNT_W'(MAX_SERVERS) && busy_b_reg <= CNT_W'(MAX_SERVERS))
        else $error("busy count above pool size");

    a_pack_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> wr_idx_reg <= rd_idx_reg)
        else $error("packed write pointer passed read pointer");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_SCAN && rd_idx_reg == '0)
        else $error("accepted item did not start a scan");

    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ALLOC && out_free && admit |=> m_valid_reg && out_adm_reg)
        else $error("admission not reported");
`endif

endmodule
